@@ rtl/serial_mux_register_device_top_defines.svh @@
// Assertion helpers for the top module, which checks its own logic.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef SERIAL_MUX_REGISTER_DEVICE_TOP_DEFINES_SVH
`define SERIAL_MUX_REGISTER_DEVICE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMRD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/smrd_pkg.sv @@
package smrd_pkg;

  localparam int LINES         = 8;
  localparam int RX_FIFO_DEPTH = 16;

  localparam int LINE_W    = 3;
  localparam int FIFO_AW   = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
  localparam int CNT_W     = $clog2(RX_FIFO_DEPTH + 1);
  localparam int MEM_DEPTH = LINES * RX_FIFO_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Request kinds.
  localparam logic [2:0] K_READ   = 3'd0;
  localparam logic [2:0] K_WRITE  = 3'd1;
  localparam logic [2:0] K_WR_LO  = 3'd2;
  localparam logic [2:0] K_WR_HI  = 3'd3;
  localparam logic [2:0] K_STATUS = 3'd4;
  localparam logic [2:0] K_RX     = 3'd5;

  // Register indexes.
  localparam logic [1:0] R_CSR  = 2'd0;
  localparam logic [1:0] R_RBUF = 2'd1;
  localparam logic [1:0] R_TCR  = 2'd2;
  localparam logic [1:0] R_MSR  = 2'd3;

  // Line connection states.
  localparam logic [1:0] LS_NONE    = 2'd0;
  localparam logic [1:0] LS_PENDING = 2'd1;
  localparam logic [1:0] LS_UP      = 2'd2;

  // Parity modes.
  localparam logic [1:0] PM_NONE = 2'd0;
  localparam logic [1:0] PM_EVEN = 2'd1;
  localparam logic [1:0] PM_ODD  = 2'd2;

  // CSR fields.
  localparam logic [15:0] CSR_RESET     = 16'h8000;
  localparam logic [15:0] CSR_WR_MASK   = 16'h5078;
  localparam logic [15:0] CSR_SCAN_KEEP = 16'hf8ff;
  localparam logic [15:0] CSR_TX_RDY    = 16'h8000;
  localparam int          CSR_CLR_BIT   = 4;
  localparam int          CSR_MSE_BIT   = 5;
  localparam int          CSR_RIE_BIT   = 6;
  localparam int          CSR_TIE_BIT   = 14;
  localparam logic [15:0] RING_KEEP     = 16'hff00;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  reg_index;
    logic [15:0] write_data;
    logic [2:0]  line;
    logic        carrier_present;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [2:0]  tx_line;
    logic [7:0]  tx_byte;
    logic        rx_irq;
    logic        tx_irq;
    logic        irq_withdraw;
    logic        rx_dropped;
  } out_t;

  // Control from the register logic to the receive FIFOs.
  typedef struct packed {
    logic              push;
    logic [LINE_W-1:0] push_line;
    logic [7:0]        push_byte;
    logic              pop;
  } rxf_ctl_t;

  // Status from the receive FIFOs.
  typedef struct packed {
    logic [LINES-1:0]  nonempty;
    logic              any;
    logic [LINE_W-1:0] pop_line;
    logic              push_full;
  } rxf_sts_t;

endpackage

@@ rtl/smrd_rx_fifo.sv @@
module smrd_rx_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  smrd_pkg::rxf_ctl_t  ctl,
  output smrd_pkg::rxf_sts_t  sts,
  output logic [7:0]          rd_byte_r
);

  localparam int SUM_W = smrd_pkg::CNT_W + 1;

  logic [smrd_pkg::FIFO_AW-1:0] head_r   [smrd_pkg::LINES];
  logic [smrd_pkg::FIFO_AW-1:0] head_nxt [smrd_pkg::LINES];
  logic [smrd_pkg::CNT_W-1:0]   cnt_r    [smrd_pkg::LINES];
  logic [smrd_pkg::CNT_W-1:0]   cnt_nxt  [smrd_pkg::LINES];
  logic [7:0]                   mem      [smrd_pkg::MEM_DEPTH];

  logic [SUM_W-1:0]              wsum;
  logic [smrd_pkg::FIFO_AW-1:0]  wpos;
  logic [smrd_pkg::MEM_AW-1:0]   waddr;
  logic [smrd_pkg::MEM_AW-1:0]   raddr;

  always_comb begin
    sts.pop_line = '0;
    for (int i = smrd_pkg::LINES - 1; i >= 0; i--) begin
      sts.nonempty[i] = (cnt_r[i] != '0);
      if (cnt_r[i] != '0) begin
        sts.pop_line = smrd_pkg::LINE_W'(i);
      end
    end
    sts.any       = |sts.nonempty;
    sts.push_full = (cnt_r[ctl.push_line] >= smrd_pkg::CNT_W'(smrd_pkg::RX_FIFO_DEPTH));
  end

  // Tail position is head plus count, wrapped once around the ring.
  always_comb begin
    wsum = SUM_W'(head_r[ctl.push_line]) + SUM_W'(cnt_r[ctl.push_line]);
    if (wsum >= SUM_W'(smrd_pkg::RX_FIFO_DEPTH)) begin
      wsum = wsum - SUM_W'(smrd_pkg::RX_FIFO_DEPTH);
    end
    wpos  = wsum[smrd_pkg::FIFO_AW-1:0];
    waddr = smrd_pkg::MEM_AW'(ctl.push_line) * smrd_pkg::MEM_AW'(smrd_pkg::RX_FIFO_DEPTH)
            + smrd_pkg::MEM_AW'(wpos);
    raddr = smrd_pkg::MEM_AW'(sts.pop_line) * smrd_pkg::MEM_AW'(smrd_pkg::RX_FIFO_DEPTH)
            + smrd_pkg::MEM_AW'(head_r[sts.pop_line]);
  end

  always_comb begin
    for (int i = 0; i < smrd_pkg::LINES; i++) begin
      head_nxt[i] = head_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (ctl.pop && (sts.pop_line == smrd_pkg::LINE_W'(i))) begin
        if (head_r[i] == smrd_pkg::FIFO_AW'(smrd_pkg::RX_FIFO_DEPTH - 1)) begin
          head_nxt[i] = '0;
        end else begin
          head_nxt[i] = head_r[i] + 1'b1;
        end
        cnt_nxt[i] = cnt_nxt[i] - 1'b1;
      end
      if (ctl.push && (ctl.push_line == smrd_pkg::LINE_W'(i))) begin
        cnt_nxt[i] = cnt_nxt[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < smrd_pkg::LINES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < smrd_pkg::LINES; i++) begin
        head_r[i] <= head_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[waddr] <= ctl.push_byte;
    end
    if (ctl.pop) begin
      rd_byte_r <= mem[raddr];
    end
  end

endmodule

@@ rtl/serial_mux_register_device_top.sv @@
// Eight-line serial multiplexer register block. Each request is a host register
// read, a word or byte register write, a line carrier change or a received byte,
// and each request gives exactly one result. One request is accepted every clock
// cycle unless both stages are full and the output is stalled. The result is
// registered in the first stage at acceptance and then in the output register;
// a stalled output holds it there and blocks new requests once both stages are
// full.
// Register and line state is updated at acceptance, in the same cycle the
// per-line receive FIFO store is read; the second stage adds the line number and
// the parity bit to a popped RBUF byte. The FIFO store has one write and one read
// port, which is what holds the block to one request per cycle. The store needs
// no clearing pass after reset, so requests are taken right away.
`include "serial_mux_register_device_top_defines.svh"

module serial_mux_register_device_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  smrd_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output smrd_pkg::out_t  out_data
);

  typedef struct packed {
    smrd_pkg::out_t              res;
    logic                        pop;
    logic [smrd_pkg::LINE_W-1:0] pop_line;
    logic [1:0]                  pop_mode;
  } stg_t;

  logic [15:0] csr_r, csr_nxt;
  logic [15:0] rbuf_r, rbuf_nxt;
  logic [15:0] tcr_r, tcr_nxt;
  logic [15:0] msr_r, msr_nxt;
  logic [2:0]  scan_r, scan_nxt;
  logic [1:0]  link_r   [smrd_pkg::LINES];
  logic [1:0]  link_nxt [smrd_pkg::LINES];
  logic [1:0]  par_r    [smrd_pkg::LINES];
  logic [1:0]  par_nxt  [smrd_pkg::LINES];

  logic           s1_valid_r;
  stg_t           s1_r, s1_nxt;
  logic           out_valid_r;
  smrd_pkg::out_t out_r, res;

  logic in_fire, adv_out;
  logic line_ok;
  logic [15:0] reg_cur, wval;
  logic [7:0]  up_vec;
  logic        clr;
  logic [15:0] csr_base;
  logic        hit;
  logic [2:0]  hit_line;
  logic [7:0]  m_lo;
  logic        par_bit;

  smrd_pkg::rxf_ctl_t rxf_ctl;
  smrd_pkg::rxf_sts_t rxf_sts;
  logic [7:0]         rd_byte_r;

  smrd_rx_fifo u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rxf_ctl),
    .sts       (rxf_sts),
    .rd_byte_r (rd_byte_r)
  );

  assign adv_out   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv_out;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign line_ok   = (int'(in_data.line) < smrd_pkg::LINES);

  always_comb begin
    up_vec = '0;
    for (int i = 0; i < smrd_pkg::LINES; i++) begin
      up_vec[i] = (link_r[i] != smrd_pkg::LS_NONE);
    end
  end

  always_comb begin
    unique case (in_data.reg_index)
      smrd_pkg::R_CSR:  reg_cur = csr_r;
      smrd_pkg::R_RBUF: reg_cur = rbuf_r;
      smrd_pkg::R_TCR:  reg_cur = tcr_r;
      smrd_pkg::R_MSR:  reg_cur = msr_r;
      default:          reg_cur = msr_r;
    endcase
    if (in_data.kind == smrd_pkg::K_WR_LO) begin
      wval = {reg_cur[15:8], in_data.write_data[7:0]};
    end else if (in_data.kind == smrd_pkg::K_WR_HI) begin
      wval = {in_data.write_data[7:0], reg_cur[7:0]};
    end else begin
      wval = in_data.write_data;
    end
  end

  always_comb begin
    rxf_ctl.push      = in_fire && (in_data.kind == smrd_pkg::K_RX) && line_ok
                        && !rxf_sts.push_full;
    rxf_ctl.push_line = in_data.line;
    rxf_ctl.push_byte = in_data.rx_byte;
    rxf_ctl.pop       = in_fire && (in_data.kind == smrd_pkg::K_READ)
                        && (in_data.reg_index == smrd_pkg::R_RBUF) && rxf_sts.any;
  end

  always_comb begin
    csr_nxt  = csr_r;
    rbuf_nxt = rbuf_r;
    tcr_nxt  = tcr_r;
    msr_nxt  = msr_r;
    scan_nxt = scan_r;
    for (int i = 0; i < smrd_pkg::LINES; i++) begin
      link_nxt[i] = link_r[i];
      par_nxt[i]  = par_r[i];
    end
    s1_nxt   = '0;
    clr      = wval[smrd_pkg::CSR_CLR_BIT];
    csr_base = clr ? 16'h0 : csr_r;
    hit      = 1'b0;
    hit_line = '0;
    m_lo     = 8'h01 << in_data.line;

    if (in_fire) begin
      unique case (in_data.kind)
        smrd_pkg::K_READ: begin
          unique case (in_data.reg_index)
            smrd_pkg::R_CSR: begin
              // A set clear bit wipes the registers as they are read.
              if (csr_r[smrd_pkg::CSR_CLR_BIT]) begin
                csr_nxt  = '0;
                rbuf_nxt = '0;
                tcr_nxt  = '0;
                msr_nxt  = '0;
              end
              s1_nxt.res.read_data = {!csr_r[smrd_pkg::CSR_CLR_BIT] && (|tcr_r[7:0]),
                                      csr_r[14:11], scan_r, rxf_sts.any,
                                      csr_r[6:3], 3'b000};
            end
            smrd_pkg::R_RBUF: begin
              s1_nxt.pop      = rxf_sts.any;
              s1_nxt.pop_line = rxf_sts.pop_line;
              s1_nxt.pop_mode = par_r[rxf_sts.pop_line];
            end
            smrd_pkg::R_TCR: begin
              s1_nxt.res.read_data = tcr_r;
            end
            default: begin
              s1_nxt.res.read_data = {up_vec, msr_r[7:0]};
              msr_nxt = msr_r & smrd_pkg::RING_KEEP;
            end
          endcase
        end
        smrd_pkg::K_WRITE, smrd_pkg::K_WR_LO, smrd_pkg::K_WR_HI: begin
          unique case (in_data.reg_index)
            smrd_pkg::R_CSR: begin
              if (clr) begin
                rbuf_nxt          = '0;
                tcr_nxt           = '0;
                msr_nxt           = '0;
                s1_nxt.res.rx_irq = 1'b1;
              end
              csr_nxt = (csr_base & ~smrd_pkg::CSR_WR_MASK)
                        | (wval & smrd_pkg::CSR_WR_MASK)
                        | (16'(clr) << smrd_pkg::CSR_CLR_BIT);
            end
            smrd_pkg::R_RBUF: begin
              if (int'(wval[2:0]) < smrd_pkg::LINES) begin
                if (wval[6]) begin
                  par_nxt[wval[2:0]] = wval[7] ? smrd_pkg::PM_ODD : smrd_pkg::PM_EVEN;
                end else begin
                  par_nxt[wval[2:0]] = smrd_pkg::PM_NONE;
                end
              end
              rbuf_nxt = wval;
            end
            smrd_pkg::R_TCR: begin
              // Live lines set in the written value come up; the highest of them takes the scanner.
              for (int i = 0; i < smrd_pkg::LINES; i++) begin
                if (wval[i] && (link_r[i] != smrd_pkg::LS_NONE)) begin
                  link_nxt[i] = smrd_pkg::LS_UP;
                  hit         = 1'b1;
                  hit_line    = 3'(i);
                end
              end
              if (hit) begin
                csr_nxt           = (csr_r & smrd_pkg::CSR_SCAN_KEEP)
                                    | {5'b0, hit_line, 8'h00} | smrd_pkg::CSR_TX_RDY;
                scan_nxt          = hit_line;
                s1_nxt.res.tx_irq = 1'b1;
              end
              s1_nxt.res.irq_withdraw = (wval[7:0] == 8'h00);
              tcr_nxt = wval;
            end
            default: begin
              if (int'(csr_r[10:8]) < smrd_pkg::LINES) begin
                s1_nxt.res.tx_valid = 1'b1;
                s1_nxt.res.tx_line  = csr_r[10:8];
                s1_nxt.res.tx_byte  = (par_r[csr_r[10:8]] != smrd_pkg::PM_NONE)
                                      ? {1'b0, wval[6:0]} : wval[7:0];
              end
              csr_nxt           = (csr_r & smrd_pkg::CSR_SCAN_KEEP)
                                  | {5'b0, csr_r[10:8], 8'h00} | smrd_pkg::CSR_TX_RDY;
              scan_nxt          = csr_r[10:8];
              s1_nxt.res.tx_irq = csr_r[smrd_pkg::CSR_TIE_BIT]
                                  && csr_r[smrd_pkg::CSR_MSE_BIT];
              msr_nxt           = wval;
            end
          endcase
        end
        smrd_pkg::K_STATUS: begin
          if (line_ok && (in_data.carrier_present
                          != (link_r[in_data.line] != smrd_pkg::LS_NONE))) begin
            if (in_data.carrier_present) begin
              link_nxt[in_data.line] = smrd_pkg::LS_PENDING;
              msr_nxt = msr_r | {m_lo, m_lo};
            end else begin
              link_nxt[in_data.line] = smrd_pkg::LS_NONE;
              msr_nxt = msr_r & ~{m_lo, m_lo};
              tcr_nxt = tcr_r & ~{m_lo, 8'h00};
            end
          end
        end
        smrd_pkg::K_RX: begin
          if (line_ok) begin
            if (rxf_sts.push_full) begin
              s1_nxt.res.rx_dropped = 1'b1;
            end else begin
              s1_nxt.res.rx_irq = csr_r[smrd_pkg::CSR_RIE_BIT]
                                  && csr_r[smrd_pkg::CSR_MSE_BIT];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Second stage: a popped byte gets its line number and parity bit.
  always_comb begin
    res     = s1_r.res;
    par_bit = 1'b0;
    if (s1_r.pop_mode == smrd_pkg::PM_EVEN) begin
      par_bit = ~^rd_byte_r;
    end else if (s1_r.pop_mode == smrd_pkg::PM_ODD) begin
      par_bit = ^rd_byte_r;
    end
    if (s1_r.pop) begin
      res.read_data = {1'b1, 4'b0000, s1_r.pop_line, rd_byte_r[7] | par_bit,
                       rd_byte_r[6:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csr_r       <= smrd_pkg::CSR_RESET;
      rbuf_r      <= '0;
      tcr_r       <= '0;
      msr_r       <= '0;
      scan_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < smrd_pkg::LINES; i++) begin
        link_r[i] <= smrd_pkg::LS_NONE;
        par_r[i]  <= smrd_pkg::PM_NONE;
      end
    end else begin
      csr_r  <= csr_nxt;
      rbuf_r <= rbuf_nxt;
      tcr_r  <= tcr_nxt;
      msr_r  <= msr_nxt;
      scan_r <= scan_nxt;
      for (int i = 0; i < smrd_pkg::LINES; i++) begin
        link_r[i] <= link_nxt[i];
        par_r[i]  <= par_nxt[i];
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (adv_out && s1_valid_r) begin
      out_r <= res;
    end
  end

  `SMRD_ASSERT_NEXT(a_pop_staged,
    in_fire && (in_data.kind == smrd_pkg::K_READ)
      && (in_data.reg_index == smrd_pkg::R_RBUF) && rxf_sts.any,
    s1_valid_r && s1_r.pop,
    "RBUF read with data waiting did not stage a pop")
  `SMRD_ASSERT_SAME(a_stall_blocks_input,
    s1_valid_r && out_valid_r && !out_ready,
    !in_ready,
    "request accepted while both stages are full and stalled")
  `SMRD_ASSERT_SAME(a_tx_no_read_data,
    out_valid_r && out_r.tx_valid,
    out_r.read_data == 16'h0000,
    "transmit result carries read data")
  `SMRD_ASSERT_SAME(a_drop_no_irq,
    out_valid_r && out_r.rx_dropped,
    !out_r.rx_irq,
    "dropped byte raised a receive interrupt")

endmodule
